@@ design/sorted_list_engine_macros.svh @@
// ----------------------------------------------------------------------------
// sorted list engine assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, off during reset
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// types and constants shared by the sorted list engine modules
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_SORTED_INS = 3'd0,
    OP_INS_FRONT  = 3'd1,
    OP_INS_BACK   = 3'd2,
    OP_REM_MATCH  = 3'd3,
    OP_REM_FRONT  = 3'd4,
    OP_REM_BACK   = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic [2:0] op;
    logic       write_en;     // insert allowed, list not full
    logic       match_found;  // some cell holds the value to remove
  } cell_ctrl_t;

endpackage

@@ design/sle_cell.sv @@
// ----------------------------------------------------------------------------
// sle_cell
// one list position: holds an entry and its occupied flag, shifts with its
// neighbors on insert and remove
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic                    left_occ,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic                    right_occ,
  input  logic                    chain_in,
  output logic                    chain_out,
  output logic signed [VAL_W-1:0] value_nxt_o,
  output logic                    occ_nxt_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic                    occ_o
);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    occ_r, occ_nxt;
  logic                    hit;
  logic                    shift;

  // position test for the searching operations
  always_comb begin
    case (ctrl.op)
      OP_SORTED_INS: hit = !occ_r || (value_r >= in_value);
      OP_REM_MATCH:  hit = occ_r && (value_r == in_value);
      default:       hit = 1'b0;
    endcase
  end

  assign chain_out = chain_in | hit;
  assign shift     = chain_in | hit;

  always_comb begin
    value_nxt = value_r;
    occ_nxt   = occ_r;
    case (ctrl.op)
      OP_SORTED_INS: begin
        if (ctrl.write_en) begin
          value_nxt = chain_in ? left_value : (hit ? in_value : value_r);
          occ_nxt   = occ_r | left_occ;
        end
      end
      OP_INS_FRONT: begin
        if (ctrl.write_en) begin
          value_nxt = left_value;
          occ_nxt   = occ_r | left_occ;
        end
      end
      OP_INS_BACK: begin
        if (ctrl.write_en) begin
          value_nxt = occ_r ? value_r : in_value;
          occ_nxt   = occ_r | left_occ;
        end
      end
      OP_REM_MATCH: begin
        if (ctrl.match_found && shift) begin
          value_nxt = right_value;
          occ_nxt   = right_occ;
        end
      end
      OP_REM_FRONT: begin
        value_nxt = right_value;
        occ_nxt   = right_occ;
      end
      OP_REM_BACK: begin
        occ_nxt = right_occ;
      end
      OP_CLEAR: begin
        occ_nxt = 1'b0;
      end
      default: begin
        value_nxt = value_r;
        occ_nxt   = occ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (accept) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= value_nxt;
    end
  end

  assign value_nxt_o = value_nxt;
  assign occ_nxt_o   = occ_nxt;
  assign value_o     = value_r;
  assign occ_o       = occ_r;

endmodule

@@ design/sorted_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine
// bounded ordered list of signed 32-bit entries built as a chain of cells
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid / in_stall carries in_op and in_value; one
//   transaction is one list operation
//   result channel out_valid / out_stall carries out_status, out_front_value,
//   out_back_value and out_count as seen after the operation
//   every cell compares its entry with the broadcast value and shifts with
//   its neighbor in the same cycle, so an operation is a single update
//   the result is registered and shows in the cycle after acceptance
//   throughput: one transaction per cycle while the receiver takes results
//   when the receiver stalls, the held result blocks the input (in_stall
//   follows out_stall while a result waits), so nothing is lost
//   reset empties the list (count zero, no result pending); entry contents
//   are not cleared and are only read once written
// ----------------------------------------------------------------------------
module sorted_list_engine import sle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_op,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_front_value,
  output logic signed [VAL_W-1:0] out_back_value,
  output logic [4:0]              out_count
);

  logic                    accept;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] val_q   [CAPACITY];
  logic signed [VAL_W-1:0] val_nxt [CAPACITY];
  logic [CAPACITY-1:0]     occ_q, occ_nxt;
  logic [CAPACITY:0]       chain;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [1:0]              status_nxt;
  logic signed [VAL_W-1:0] front_nxt, back_nxt;
  logic                    full, empty;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r;
  logic signed [VAL_W-1:0] out_front_r, out_back_r;
  logic [4:0]              out_count_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = occ_q[CAPACITY-1];
  assign empty = !occ_q[0];

  assign ctrl.op          = in_op;
  assign ctrl.write_en    = !full;
  assign ctrl.match_found = chain[CAPACITY];

  assign chain[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VAL_W-1:0] lv, rv;
      logic                    lo, ro;
      if (gi == 0) begin : g_head
        assign lv = in_value;
        assign lo = 1'b1;
      end else begin : g_mid_l
        assign lv = val_q[gi-1];
        assign lo = occ_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign rv = '0;
        assign ro = 1'b0;
      end else begin : g_mid_r
        assign rv = val_q[gi+1];
        assign ro = occ_q[gi+1];
      end
      sle_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ctrl        (ctrl),
        .in_value    (in_value),
        .left_value  (lv),
        .left_occ    (lo),
        .right_value (rv),
        .right_occ   (ro),
        .chain_in    (chain[gi]),
        .chain_out   (chain[gi+1]),
        .value_nxt_o (val_nxt[gi]),
        .occ_nxt_o   (occ_nxt[gi]),
        .value_o     (val_q[gi]),
        .occ_o       (occ_q[gi])
      );
    end
  endgenerate

  // count and status for the transaction
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_DONE;
    case (in_op)
      OP_SORTED_INS, OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_REM_MATCH: begin
        if (chain[CAPACITY]) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt    = cnt_r;
        status_nxt = ST_DONE;
      end
    endcase
  end

  // front and back of the updated list; the last occupied cell is the back
  always_comb begin
    front_nxt = occ_nxt[0] ? val_nxt[0] : '0;
    back_nxt  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ_nxt[i] && ((i == CAPACITY - 1) || !occ_nxt[(i + 1) % CAPACITY])) begin
        back_nxt = back_nxt | val_nxt[i];
      end
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_front_r  <= front_nxt;
      out_back_r   <= back_nxt;
      out_count_r  <= 5'(cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_count       = out_count_r;

endmodule

@@ design/sle_checker.sv @@
// ----------------------------------------------------------------------------
// sle_checker
// port-level checks for the sorted list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_list_engine_macros.svh"

module sle_checker import sle_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [2:0]              in_op,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_status,
  input logic signed [VAL_W-1:0] out_front_value,
  input logic signed [VAL_W-1:0] out_back_value,
  input logic [4:0]              out_count
);

  logic                 held;
  logic                 clear_took;
  logic                 full_res;
  logic                 empty_res;
  logic                 ends_zero;
  logic [2*VAL_W+6:0]   result_bus;

  assign held       = out_valid && out_stall;
  assign clear_took = in_valid && !in_stall && (in_op == OP_CLEAR);
  assign full_res   = out_valid && (out_status == ST_FULL);
  assign empty_res  = out_valid && (CAPACITY < 32) && (out_count == 5'd0);
  assign ends_zero  = (out_front_value == '0) && (out_back_value == '0);
  assign result_bus = {out_status, out_front_value, out_back_value, out_count};

  // a held result must block new transactions
  `SLE_ASSERT_NOW(a_stall_blocks_input, held, in_stall, "input taken while result held")

  // stalled result stays put
  `SLE_ASSERT_NEXT(a_result_held, held, out_valid && $stable(result_bus), "stalled result changed")

  // refused insert only happens on a full list
  `SLE_ASSERT_NOW(a_full_count, full_res, out_count == 5'(CAPACITY), "full status with short list")

  // an empty list reports zero ends
  `SLE_ASSERT_NOW(a_empty_zero, empty_res, ends_zero, "empty list with nonzero ends")

  // a clear transaction leaves an empty list in its result
  `SLE_ASSERT_NEXT(a_clear_empty, clear_took, out_valid && (out_count == 5'd0), "clear kept entries")

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_count       (out_count)
);
